// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/fir49_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir49_pkg
// Widths, coefficient table and shared types of the 49-tap low-pass FIR.
// ----------------------------------------------------------------------------
package fir49_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 14;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int ACC_W     = 32;
	localparam int OUT_W     = 18;
	localparam int TAP_IDX_W = 8;   // covers the largest tap count
	localparam int COEF_COUNT = 49;
	localparam int COEF_IDX_W = $clog2(COEF_COUNT);

	// Divide by the scale of 10000: |sum| stays below 2**30, so the quotient fits
	// 17 bits. floor(mag * RECIP / 2**43) equals floor(mag / 10000) over that range.
	localparam int QUO_W       = 17;
	localparam int MAG_W       = 30;
	localparam int RECIP_W     = 30;
	localparam int RECIP_SHIFT = 43;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(879609303);

	localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
		14'sd46, 14'sd74, -14'sd24, -14'sd71, 14'sd33, 14'sd1, -14'sd94, 14'sd40,
		14'sd44, -14'sd133, 14'sd30, 14'sd114, -14'sd179, -14'sd11, 14'sd223, -14'sd225,
		-14'sd109, 14'sd396, -14'sd263, -14'sd338, 14'sd752, -14'sd289, -14'sd1204,
		14'sd2879, 14'sd6369, 14'sd2879, -14'sd1204, -14'sd289, 14'sd752, -14'sd338,
		-14'sd263, 14'sd396, -14'sd109, -14'sd225, 14'sd223, -14'sd11, -14'sd179,
		14'sd114, 14'sd30, -14'sd133, 14'sd44, 14'sd40, -14'sd94, 14'sd1, 14'sd33,
		-14'sd71, -14'sd24, 14'sd74, 14'sd46
	};

	// Taps past the table carry a zero weight.
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if (idx < TAP_IDX_W'(COEF_COUNT)) begin
			c = COEF_TABLE[idx[COEF_IDX_W-1:0]];
		end
		return c;
	endfunction

	// Finished weighted sum on its way to the divider.
	typedef struct packed {
		logic                    vld;
		logic signed [ACC_W-1:0] sum;
	} sum_req_t;

endpackage

// File: rtl/core/fir_filter_49_tap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_49_tap
// Symmetric low-pass FIR over the last TAPS accelerometer samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input request s_tvalid/s_tready/s_tdata carries one signed 16-bit sample.
//   Output request m_tvalid/m_tready/m_tdata carries one signed 18-bit result
//   per sample: the weighted sum of the stored samples divided by 10000,
//   truncated toward zero.
//   Each sample is written to a circular memory, then a sequencer sweeps all
//   TAPS entries through one multiplier, one tap per cycle. An item occupies
//   the input side until its sum is handed to the divider; that sweep sets the
//   rate, as no new sample is taken before then. The sum then passes to a
//   reciprocal-multiply divider (multiply, then sign restore) that runs while
//   the next sample is swept.
//   Reset clears the fill count, so entries not yet written count as zero
//   samples; no clearing pass is needed and s_tready rises at once.
//   While the receiver stalls, the result is held in the divider's output
//   register; one more sample can be taken and swept, after which s_tready
//   stays low until the held result is taken.
// ----------------------------------------------------------------------------
module fir_filter_49_tap
	import fir49_pkg::*;
#(
	parameter int TAPS = 49
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [17:0] filtered, [23:18] zero
);

	sum_req_t                sum_req;
	logic                    sum_rdy;
	logic signed [OUT_W-1:0] filtered;

	fir49_mac #(
		.TAPS(TAPS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (s_tvalid),
		.in_rdy   (s_tready),
		.in_sample(s_tdata),
		.sum_o    (sum_req),
		.sum_rdy  (sum_rdy)
	);

	fir49_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.sum_i   (sum_req),
		.sum_rdy (sum_rdy),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.out_data(filtered)
	);

	assign m_tdata = {6'b0, filtered};

endmodule

// File: rtl/core/fir49_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir49_mac
// Circular sample memory and one multiply-accumulate per tap per cycle.
// ----------------------------------------------------------------------------
module fir49_mac
	import fir49_pkg::*;
#(
	parameter int TAPS = 49
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	output logic                       in_rdy,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	output sum_req_t                   sum_o,
	input  logic                       sum_rdy
);

	localparam int AW = $clog2(TAPS);
	localparam int CW = $clog2(TAPS + 1);

	typedef enum logic [2:0] {
		MAC_IDLE = 3'b001,
		MAC_RUN  = 3'b010,
		MAC_WAIT = 3'b100
	} mac_state_t;

	mac_state_t state_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] k_q;
	logic [CW-1:0] cnt_q;

	logic signed [SAMPLE_W-1:0] mem [TAPS];
	logic signed [SAMPLE_W-1:0] rdata_s1;
	logic signed [COEF_W-1:0]   coef_s1;
	logic                       live_s1;
	logic                       vld_s1;
	logic                       last_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       vld_s2;
	logic                       last_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       sum_vld_q;

	logic accept;
	logic issue;
	logic last_tap;
	logic signed [PROD_W-1:0] prod;

	assign in_rdy   = (state_q == MAC_IDLE);
	assign accept   = in_vld && in_rdy;
	assign issue    = (state_q == MAC_RUN);
	assign last_tap = (k_q == AW'(TAPS - 1));
	assign prod     = rdata_s1 * coef_s1;

	assign sum_o.vld = sum_vld_q;
	assign sum_o.sum = acc_q;

	// New sample goes to the write pointer; the sweep reads back from there,
	// newest first. No item enters until the sweep is over, so reads and the
	// next write never touch the same entry in one cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wp_q] <= in_sample;
		end
		rdata_s1 <= mem[rd_q];
		coef_s1  <= coef_at(TAP_IDX_W'(k_q));
		live_s1  <= (CW'(k_q) < cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= MAC_IDLE;
			wp_q      <= '0;
			rd_q      <= '0;
			k_q       <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			vld_s2    <= 1'b0;
			last_s2   <= 1'b0;
			sum_vld_q <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= issue && last_tap;
			vld_s2  <= vld_s1;
			last_s2 <= vld_s1 && last_s1;

			unique case (state_q)
				MAC_IDLE: begin
					if (accept) begin
						rd_q    <= wp_q;
						wp_q    <= (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
						k_q     <= '0;
						if (cnt_q != CW'(TAPS)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= MAC_RUN;
					end
				end
				MAC_RUN: begin
					rd_q <= (rd_q == '0) ? AW'(TAPS - 1) : rd_q - 1'b1;
					k_q  <= k_q + 1'b1;
					if (last_tap) begin
						state_q <= MAC_WAIT;
					end
				end
				MAC_WAIT: begin
					if (vld_s2 && last_s2) begin
						sum_vld_q <= 1'b1;
					end
					if (sum_vld_q && sum_rdy) begin
						sum_vld_q <= 1'b0;
						state_q   <= MAC_IDLE;
					end
				end
				default: begin
					state_q <= MAC_IDLE;
				end
			endcase
		end
	end

	// Entries older than the fill count were never written: weigh them as zero.
	always_ff @(posedge clk) begin
		prod_s2 <= live_s1 ? prod : '0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

endmodule

// File: rtl/core/fir49_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir49_div
// Divide of the weighted sum by the coefficient scale through a reciprocal
// multiply, truncating toward zero; holds the result for the output.
// ----------------------------------------------------------------------------
module fir49_div
	import fir49_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  sum_req_t                sum_i,
	output logic                    sum_rdy,
	output logic                    out_vld,
	input  logic                    out_rdy,
	output logic signed [OUT_W-1:0] out_data
);

	localparam int PRODUCT_W = MAG_W + RECIP_W;

	typedef enum logic [3:0] {
		DIV_IDLE = 4'b0001,
		DIV_MUL  = 4'b0010,
		DIV_SIGN = 4'b0100,
		DIV_DONE = 4'b1000
	} div_state_t;

	div_state_t state_q;
	logic                    neg_q;
	logic [MAG_W-1:0]        mag_q;
	logic [PRODUCT_W-1:0]    prod_q;
	logic signed [OUT_W-1:0] out_q;

	logic [ACC_W-1:0] mag;
	logic [QUO_W-1:0] quo;

	assign sum_rdy  = (state_q == DIV_IDLE);
	assign out_vld  = (state_q == DIV_DONE);
	assign out_data = out_q;

	always_comb begin
		mag = sum_i.sum[ACC_W-1] ? ACC_W'(-sum_i.sum) : ACC_W'(sum_i.sum);
		quo = prod_q[PRODUCT_W-1:RECIP_SHIFT];
	end

	// Divide the magnitude, then restore the sign.
	always_ff @(posedge clk) begin
		unique case (state_q)
			DIV_IDLE: begin
				neg_q <= sum_i.sum[ACC_W-1];
				mag_q <= mag[MAG_W-1:0];
			end
			DIV_MUL: begin
				prod_q <= mag_q * RECIP;
			end
			DIV_SIGN: begin
				out_q <= neg_q ? -OUT_W'(quo) : OUT_W'(quo);
			end
			DIV_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			unique case (state_q)
				DIV_IDLE: begin
					if (sum_i.vld) begin
						state_q <= DIV_MUL;
					end
				end
				DIV_MUL: begin
					state_q <= DIV_SIGN;
				end
				DIV_SIGN: begin
					state_q <= DIV_DONE;
				end
				DIV_DONE: begin
					if (out_rdy) begin
						state_q <= DIV_IDLE;
					end
				end
				default: begin
					state_q <= DIV_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/fir49_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir49_checker
// Port-level checks of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fir49_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A stalled result holds.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Padding bits above the result stay zero.
	`ASSERT_SAME(a_out_pad, m_tvalid, m_tdata[23:18] == 6'b0)

	// A taken sample starts a sweep, so the input closes for the next cycle.
	`ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready)

	// A delivered result is never followed by another in the next cycle.
	`ASSERT_NEXT(a_out_gap, m_tvalid && m_tready, !m_tvalid)

endmodule

bind fir_filter_49_tap fir49_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
